[design/rlda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlda_pkg
// Shared widths, defaults and the lookup record of the loss delta aggregator.
// ----------------------------------------------------------------------------
package rlda_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int SSRC_W = 32;
    localparam int SEQ_W  = 32;
    localparam int LOST_W = 24;
    localparam int SUM_W  = 32;
    localparam int RECV_W = 31;
    localparam int TIME_W = 48;

    typedef struct packed {
        logic             hit;
        logic             full;
        logic [SUM_W-1:0] seq_delta;
        logic [SUM_W-1:0] lost_delta;
    } rlda_lookup_t;

endpackage
`default_nettype wire

[design/rlda_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlda_table
// Source table: parallel tag compare, lowest free slot, per-source deltas.
// ----------------------------------------------------------------------------
module rlda_table #(
    parameter int TABLE_ENTRIES = rlda_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               fire,
    input  wire        [rlda_pkg::SSRC_W-1:0] ssrc,
    input  wire        [rlda_pkg::SEQ_W-1:0]  seq,
    input  wire        [rlda_pkg::LOST_W-1:0] lost,
    output rlda_pkg::rlda_lookup_t            lookup
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0]  entry_valid_reg;
    logic [rlda_pkg::SSRC_W-1:0] entry_ssrc_reg [TABLE_ENTRIES];
    logic [rlda_pkg::SEQ_W-1:0]  entry_seq_reg  [TABLE_ENTRIES];
    logic [rlda_pkg::LOST_W-1:0] entry_lost_reg [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0]  match;
    logic                      hit;
    logic                      free;
    logic [IDX_W-1:0]          hit_idx;
    logic [IDX_W-1:0]          free_idx;
    logic [rlda_pkg::SEQ_W-1:0]  old_seq;
    logic [rlda_pkg::LOST_W-1:0] old_lost;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = entry_valid_reg[i] && (entry_ssrc_reg[i] == ssrc);
        end
    end

    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!entry_valid_reg[i]) begin
                free     = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign old_seq  = entry_seq_reg[hit_idx];
    assign old_lost = entry_lost_reg[hit_idx];

    always_comb begin
        lookup.hit        = hit;
        lookup.full       = !free;
        lookup.seq_delta  = seq - old_seq;
        lookup.lost_delta = {{(rlda_pkg::SUM_W - rlda_pkg::LOST_W){lost[rlda_pkg::LOST_W-1]}},
                             lost}
                          - {{(rlda_pkg::SUM_W - rlda_pkg::LOST_W){old_lost[rlda_pkg::LOST_W-1]}},
                             old_lost};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (fire && !hit && free) begin
            entry_valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (hit) begin
                entry_seq_reg[hit_idx]  <= seq;
                entry_lost_reg[hit_idx] <= lost;
            end else if (free) begin
                entry_ssrc_reg[free_idx] <= ssrc;
                entry_seq_reg[free_idx]  <= seq;
                entry_lost_reg[free_idx] <= lost;
            end
        end
    end

    // source ids in the table are unique
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match))
        else $error("rlda_table: more than one entry matches");

    a_new_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !hit && free |=>
            $countones(entry_valid_reg) == $past($countones(entry_valid_reg)) + 1)
        else $error("rlda_table: new source not stored");

endmodule
`default_nettype wire

[design/rlda_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlda_accum
// Per-report delta totals, drop flag, window start and emit decision.
// ----------------------------------------------------------------------------
module rlda_accum (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                fire,
    input  wire                                last,
    input  wire         [rlda_pkg::TIME_W-1:0] now_ms,
    input  rlda_pkg::rlda_lookup_t             lookup,
    output logic                               emit,
    output logic signed [rlda_pkg::SUM_W-1:0]  lost_delta,
    output logic        [rlda_pkg::RECV_W-1:0] recv_delta,
    output logic        [rlda_pkg::TIME_W-1:0] start_ms,
    output logic                               dropped
);

    logic [rlda_pkg::SUM_W-1:0]  sum_seq_reg;
    logic [rlda_pkg::SUM_W-1:0]  sum_lost_reg;
    logic                        drop_seen_reg;
    logic [rlda_pkg::TIME_W-1:0] window_start_reg;

    logic [rlda_pkg::SUM_W-1:0]  sum_seq_next;
    logic [rlda_pkg::SUM_W-1:0]  sum_lost_next;
    logic                        drop_seen_next;
    logic [rlda_pkg::SUM_W-1:0]  received;

    always_comb begin
        sum_seq_next   = sum_seq_reg;
        sum_lost_next  = sum_lost_reg;
        drop_seen_next = drop_seen_reg;
        if (lookup.hit) begin
            sum_seq_next  = sum_seq_reg + lookup.seq_delta;
            sum_lost_next = sum_lost_reg + lookup.lost_delta;
        end else if (lookup.full) begin
            drop_seen_next = 1'b1;
        end
        received = sum_seq_next - sum_lost_next;
        emit = last && (sum_seq_next != '0) && (received != '0)
            && !received[rlda_pkg::SUM_W-1];
    end

    assign lost_delta = $signed(sum_lost_next);
    assign recv_delta = received[rlda_pkg::RECV_W-1:0];
    assign start_ms   = window_start_reg;
    assign dropped    = drop_seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_seq_reg      <= '0;
            sum_lost_reg     <= '0;
            drop_seen_reg    <= 1'b0;
            window_start_reg <= '0;
        end else if (fire) begin
            if (last) begin
                sum_seq_reg   <= '0;
                sum_lost_reg  <= '0;
                drop_seen_reg <= 1'b0;
                if (emit) begin
                    window_start_reg <= now_ms;
                end
            end else begin
                sum_seq_reg   <= sum_seq_next;
                sum_lost_reg  <= sum_lost_next;
                drop_seen_reg <= drop_seen_next;
            end
        end
    end

    a_report_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last |=> sum_seq_reg == '0 && sum_lost_reg == '0 && !drop_seen_reg)
        else $error("rlda_accum: totals not cleared at end of report");

    a_window_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && emit) |=> $stable(window_start_reg))
        else $error("rlda_accum: window start moved without a report");

endmodule
`default_nettype wire

[design/rtcp_loss_delta_aggregator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcp_loss_delta_aggregator_unit
// RTCP receiver report loss delta aggregator, one report block per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one report block. It is captured in an input
// register, looked up in a TABLE_ENTRIES-deep source table by parallel tag
// compare, and its sequence and lost-count deltas are added to the report
// totals when it leaves the input register; the table and totals update
// in that same cycle, so one block per clock is sustained with m_ready
// high. A block marked last_in_report may produce one result, held in an
// output register; a waiting result stalls the input register but the
// block still takes one more transaction. A new source that finds the
// table full is not stored and sets sources_dropped in the report. The
// table starts empty after reset and entries are never evicted.
// ----------------------------------------------------------------------------
module rtcp_loss_delta_aggregator_unit #(
    parameter int TABLE_ENTRIES = rlda_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire         [rlda_pkg::SSRC_W-1:0] s_ssrc,
    input  wire         [rlda_pkg::SEQ_W-1:0]  s_ext_high_seq,
    input  wire  signed [rlda_pkg::LOST_W-1:0] s_cumulative_lost,
    input  wire         [rlda_pkg::TIME_W-1:0] s_now_ms,
    input  wire                                s_last_in_report,

    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [rlda_pkg::SUM_W-1:0]  m_lost_count_delta,
    output logic        [rlda_pkg::RECV_W-1:0] m_received_count_delta,
    output logic        [rlda_pkg::TIME_W-1:0] m_start_time_ms,
    output logic        [rlda_pkg::TIME_W-1:0] m_end_time_ms,
    output logic                               m_sources_dropped
);

    logic                        in_valid_reg;
    logic [rlda_pkg::SSRC_W-1:0] ssrc_reg;
    logic [rlda_pkg::SEQ_W-1:0]  seq_reg;
    logic [rlda_pkg::LOST_W-1:0] lost_reg;
    logic [rlda_pkg::TIME_W-1:0] now_reg;
    logic                        last_reg;

    logic                        out_valid_reg;
    logic signed [rlda_pkg::SUM_W-1:0] lost_delta_reg;
    logic [rlda_pkg::RECV_W-1:0] recv_delta_reg;
    logic [rlda_pkg::TIME_W-1:0] start_reg;
    logic [rlda_pkg::TIME_W-1:0] end_reg;
    logic                        dropped_reg;

    logic                        out_free;
    logic                        fire;
    logic                        emit;
    logic signed [rlda_pkg::SUM_W-1:0] lost_delta;
    logic [rlda_pkg::RECV_W-1:0] recv_delta;
    logic [rlda_pkg::TIME_W-1:0] start_ms;
    logic                        dropped;
    rlda_pkg::rlda_lookup_t      lookup;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ssrc_reg <= s_ssrc;
            seq_reg  <= s_ext_high_seq;
            lost_reg <= s_cumulative_lost;
            now_reg  <= s_now_ms;
            last_reg <= s_last_in_report;
        end
    end

    rlda_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ssrc    (ssrc_reg),
        .seq     (seq_reg),
        .lost    (lost_reg),
        .lookup  (lookup)
    );

    rlda_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .last       (last_reg),
        .now_ms     (now_reg),
        .lookup     (lookup),
        .emit       (emit),
        .lost_delta (lost_delta),
        .recv_delta (recv_delta),
        .start_ms   (start_ms),
        .dropped    (dropped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            lost_delta_reg <= lost_delta;
            recv_delta_reg <= recv_delta;
            start_reg      <= start_ms;
            end_reg        <= now_reg;
            dropped_reg    <= dropped;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_lost_count_delta     = lost_delta_reg;
    assign m_received_count_delta = recv_delta_reg;
    assign m_start_time_ms        = start_reg;
    assign m_end_time_ms          = end_reg;
    assign m_sources_dropped      = dropped_reg;

    a_recv_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_received_count_delta != '0)
        else $error("rtcp_loss_delta_aggregator_unit: zero received delta reported");

endmodule
`default_nettype wire
